### hw/rtl/sdr_pkg.sv
// Shared types and constants for the stream duplicate remover.
// No dependencies; every other file of the block refers to this package.
package sdr_pkg;

  // Widths of the request and result fields.
  localparam int VALUE_W = 64;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  // Default number of unique values one set may hold.
  localparam int DEPTH_DEFAULT = 64;

  // Control flags that travel with a request down the cell chain.
  typedef struct packed {
    logic valid;    // stage holds a request
    logic restart;  // request opens a new set
    logic ovf;      // set was already full; request changes nothing
    logic found;    // request is resolved (matched or stored)
    logic kept;     // request was stored as a new unique value
  } flags_t;

endpackage

### hw/rtl/sdr_if.sv
// Valid/ready channel interfaces for the stream duplicate remover.
// Depends on sdr_pkg for the field widths.

// Request channel: one value and its restart mark.
interface sdr_in_if;
  logic                         valid;
  logic                         ready;
  logic [sdr_pkg::VALUE_W-1:0]  value;
  logic                         restart;

  modport source (output valid, output value, output restart, input ready);
  modport sink   (input valid, input value, input restart, output ready);
endinterface

// Result channel: echoed value with its classification.
interface sdr_out_if;
  logic                         valid;
  logic                         ready;
  logic [sdr_pkg::VALUE_W-1:0]  out_value;
  logic                         kept;
  logic [sdr_pkg::SLOT_W-1:0]   slot;
  logic [sdr_pkg::COUNT_W-1:0]  unique_count;
  logic                         overflow;

  modport source (output valid, output out_value, output kept, output slot,
                  output unique_count, output overflow, input ready);
  modport sink   (input valid, input out_value, input kept, input slot,
                  input unique_count, input overflow, output ready);
endinterface

### hw/rtl/stream_duplicate_remover.sv
// Top level of the stream duplicate remover: set admission counter and
// the row of DEPTH comparison cells. Depends on sdr_pkg, sdr_if, sdr_cell.
//
// Values stream through a row of DEPTH cells, one cell per cycle while the
// row is not held, and each cell holds one unique value of the current set.
// A request is accepted in every cycle in which the result channel is not
// stalled, and its result passes through every cell of the row before it
// can be taken; results leave in request order. While a finished result
// waits at the output the whole row holds. A restart request clears each
// cell as it passes, so requests of the previous set ahead of it are
// unaffected.
module stream_duplicate_remover #(
  parameter int DEPTH = sdr_pkg::DEPTH_DEFAULT
) (
  input logic            clk,
  input logic            rst,
  sdr_in_if.sink         din,
  sdr_out_if.source      dout
);

  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  // Chain wiring between stages: index 0 feeds the first cell.
  sdr_pkg::flags_t             flags [0:DEPTH];
  logic [sdr_pkg::VALUE_W-1:0] value [0:DEPTH];
  logic [SW-1:0]               slot  [0:DEPTH];
  logic [CW-1:0]               count [0:DEPTH];

  logic          adv;
  logic [CW-1:0] items_in_set;
  logic          full;

  logic [SW+sdr_pkg::SLOT_W-1:0]  slot_ext;
  logic [CW+sdr_pkg::COUNT_W-1:0] count_ext;

  // The row moves whenever the output stage is empty or being taken.
  assign adv      = !flags[DEPTH].valid || dout.ready;
  assign din.ready = adv;

  // Items in the current set, saturating at DEPTH; a restart reopens it.
  assign full = (items_in_set >= DEPTH_CNT) && !din.restart;

  always_ff @(posedge clk) begin
    if (rst) begin
      items_in_set <= '0;
    end else if (din.valid && adv) begin
      if (din.restart) begin
        items_in_set <= CW'(1);
      end else if (!full) begin
        items_in_set <= items_in_set + CW'(1);
      end
    end
  end

  // Request entering the row.
  always_comb begin
    flags[0].valid   = din.valid;
    flags[0].restart = din.restart;
    flags[0].ovf     = full;
    flags[0].found   = 1'b0;
    flags[0].kept    = 1'b0;
    value[0]         = din.value;
    slot[0]          = '0;
    count[0]         = '0;
  end

  // Row of comparison cells.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    sdr_cell #(
      .INDEX (k),
      .SW    (SW),
      .CW    (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .flags_in  (flags[k]),
      .value_in  (value[k]),
      .slot_in   (slot[k]),
      .count_in  (count[k]),
      .flags_out (flags[k+1]),
      .value_out (value[k+1]),
      .slot_out  (slot[k+1]),
      .count_out (count[k+1])
    );
  end

  // Result fields wrap to their channel widths.
  assign slot_ext  = {{sdr_pkg::SLOT_W{1'b0}}, slot[DEPTH]};
  assign count_ext = {{sdr_pkg::COUNT_W{1'b0}}, count[DEPTH]};

  assign dout.valid        = flags[DEPTH].valid;
  assign dout.out_value    = value[DEPTH];
  assign dout.kept         = flags[DEPTH].kept;
  assign dout.slot         = slot_ext[sdr_pkg::SLOT_W-1:0];
  assign dout.unique_count = count_ext[sdr_pkg::COUNT_W-1:0];
  assign dout.overflow     = flags[DEPTH].ovf;

endmodule

### hw/rtl/sdr_cell.sv
// One cell of the duplicate remover chain: holds one stored value and
// passes each request on to the next cell. Depends on sdr_pkg.
module sdr_cell #(
  parameter int INDEX = 0,
  parameter int SW    = 6,
  parameter int CW    = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  sdr_pkg::flags_t               flags_in,
  input  logic [sdr_pkg::VALUE_W-1:0]   value_in,
  input  logic [SW-1:0]                 slot_in,
  input  logic [CW-1:0]                 count_in,
  output sdr_pkg::flags_t               flags_out,
  output logic [sdr_pkg::VALUE_W-1:0]   value_out,
  output logic [SW-1:0]                 slot_out,
  output logic [CW-1:0]                 count_out
);

  localparam logic [SW-1:0] MY_SLOT  = SW'(INDEX);
  localparam logic [CW-1:0] MY_COUNT = CW'(INDEX + 1);

  // Cell contents. The filled flags of the whole row form the stored
  // count in thermometer code; filled cells are always a prefix.
  logic                        filled;
  logic [sdr_pkg::VALUE_W-1:0] data;

  logic                        held;
  logic                        hit;
  logic                        store;
  sdr_pkg::flags_t             flags_next;

  // A restart request sees the cell as empty.
  assign held  = filled && !flags_in.restart;
  assign hit   = flags_in.valid && !flags_in.ovf && !flags_in.found && held &&
                 (data == value_in);
  assign store = flags_in.valid && !flags_in.ovf && !flags_in.found && !held;

  always_comb begin
    flags_next       = flags_in;
    flags_next.found = flags_in.found || hit || store;
    flags_next.kept  = flags_in.kept || store;
  end

  // Cell state and the registered request flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= 1'b0;
      flags_out <= '0;
    end else if (adv) begin
      if (store) begin
        filled <= 1'b1;
      end else if (flags_in.valid && flags_in.restart) begin
        filled <= 1'b0;
      end
      flags_out <= flags_next;
    end
  end

  // Stored value and the registered request payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (store) begin
        data <= value_in;
      end
      value_out <= value_in;
      slot_out  <= (hit || store) ? MY_SLOT : slot_in;
      count_out <= (held || store) ? MY_COUNT : count_in;
    end
  end

endmodule

### sim/tb.sv
// Self-checking testbench for stream_duplicate_remover: directed and random sets of requests.
// Depends on sdr_pkg, the sdr_in_if/sdr_out_if interfaces and the RTL of the block.
module tb;

  localparam int DEPTH       = sdr_pkg::DEPTH_DEFAULT;
  localparam int LATENCY     = DEPTH;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_GAP     = 60;
  localparam int IDLE_LIMIT  = 4 * (HOLD_CYCLES + LATENCY + 2 * MAX_GAP);
  localparam int N_REQUESTS  = 1300;
  localparam int MAX_REPORTS = 10;

  // One classified value as it leaves the block.
  typedef struct packed {
    logic [sdr_pkg::VALUE_W-1:0] value;
    logic                        kept;
    logic [sdr_pkg::SLOT_W-1:0]  slot;
    logic [sdr_pkg::COUNT_W-1:0] unique_count;
    logic                        overflow;
  } dedup_result_t;

  // Tracks the unique values of the current set and the results still owed.
  class dedup_scoreboard;
    logic [sdr_pkg::VALUE_W-1:0] uniques[DEPTH];
    int stored;
    int set_items;
    dedup_result_t pending[$];
    int errors;
    int n_requests, n_results, n_sets, n_kept, n_repeats, n_overflow;

    // Classifies an accepted request and queues the result it must produce.
    function void note_request(logic [sdr_pkg::VALUE_W-1:0] v, logic restart);
      dedup_result_t want;
      bit hit;
      want = '0;
      want.value = v;
      hit = 1'b0;
      n_requests++;
      if (restart) begin
        stored = 0;
        set_items = 0;
        n_sets++;
      end
      if (set_items >= DEPTH) begin
        // The set is full, so the value is ignored and nothing changes.
        want.overflow = 1'b1;
        n_overflow++;
      end else begin
        set_items++;
        for (int k = 0; k < stored; k++) begin
          if (!hit && uniques[k] == v) begin
            hit = 1'b1;
            want.slot = sdr_pkg::SLOT_W'(k);
          end
        end
        if (!hit && stored < DEPTH) begin
          uniques[stored] = v;
          want.slot = sdr_pkg::SLOT_W'(stored);
          want.kept = 1'b1;
          stored++;
          n_kept++;
        end else begin
          n_repeats++;
        end
      end
      want.unique_count = sdr_pkg::COUNT_W'(stored);
      pending = {pending, want};
    endfunction

    function void flag(string what, logic [sdr_pkg::VALUE_W-1:0] want,
                       logic [sdr_pkg::VALUE_W-1:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch in %s at result %0d: expected %h, got %h",
                 what, n_results, want, got);
    endfunction

    // Compares one accepted result with the oldest one owed.
    function void check_result(dedup_result_t got);
      dedup_result_t want;
      n_results++;
      if (pending.size() == 0) begin
        flag("unexpected result value", '0, got.value);
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value) flag("out_value", want.value, got.value);
      if (got.kept !== want.kept) flag("kept", want.kept, got.kept);
      if (got.slot !== want.slot) flag("slot", want.slot, got.slot);
      if (got.unique_count !== want.unique_count)
        flag("unique_count", want.unique_count, got.unique_count);
      if (got.overflow !== want.overflow) flag("overflow", want.overflow, got.overflow);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   hold_due = 1'b0;
  int   idle_cycles = 0;
  dedup_scoreboard sb = new();

  sdr_in_if  req_ch ();
  sdr_out_if res_ch ();

  stream_duplicate_remover #(.DEPTH(DEPTH)) u_top (
    .clk  (clk),
    .rst  (rst),
    .din  (req_ch),
    .dout (res_ch)
  );

  // Free-running clock.
  always #10 clk = ~clk;

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, MAX_GAP);
  endfunction

  // Random word with a bias toward zero, all ones, single-bit patterns and their inverses.
  function automatic logic [sdr_pkg::VALUE_W-1:0] rand_word();
    int pick;
    int b;
    pick = $urandom_range(0, 19);
    b = $urandom_range(0, sdr_pkg::VALUE_W - 1);
    case (pick)
      0: return '0;
      1: return '1;
      2: return sdr_pkg::VALUE_W'(1) << b;
      3: return ~(sdr_pkg::VALUE_W'(1) << b);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offers one request after an optional gap and waits until it is taken.
  task automatic send_request(logic [sdr_pkg::VALUE_W-1:0] v, logic r, bit burst);
    int gap;
    gap = burst ? 0 : pick_idle();
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      req_ch.value <= {$urandom, $urandom};
    end
    @(negedge clk);
    req_ch.valid   <= 1'b1;
    req_ch.value   <= v;
    req_ch.restart <= r;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(v, r);
  endtask

  // Sends one set drawn from a pool, either in order with distinct words or at random.
  task automatic send_set(int len, int pool_size, bit distinct, bit restart_first);
    logic [sdr_pkg::VALUE_W-1:0] pool[$];
    logic [sdr_pkg::VALUE_W-1:0] v;
    logic r;
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    repeat (pool_size) begin
      v = distinct ? {$urandom, $urandom} : rand_word();
      pool = {pool, v};
    end
    for (int i = 0; i < len; i++) begin
      if (distinct) begin
        v = pool[i % pool_size];
      end else if ($urandom_range(0, 7) == 0) begin
        v = rand_word();
      end else begin
        v = pool[$urandom_range(0, pool_size - 1)];
      end
      r = (i == 0) ? restart_first : ($urandom_range(0, 199) == 0);
      send_request(v, r, burst);
    end
  endtask

  // Result side: random stalls, long free stretches and one long hold-off.
  initial begin
    int ready_run;
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      if (hold_due) begin
        hold_due = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          res_ch.ready <= 1'b0;
        end
      end
      ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                              : $urandom_range(1, 30);
      repeat (ready_run) begin
        @(negedge clk);
        res_ch.ready <= 1'b1;
      end
      stall = pick_idle();
      repeat (stall) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
      end
    end
  end

  // Every accepted result is checked against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
      sb.check_result({res_ch.out_value, res_ch.kept, res_ch.slot,
                       res_ch.unique_count, res_ch.overflow});
  end

  // Watchdog on cycles in which neither side moves anything.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results still owed",
               IDLE_LIMIT, sb.pending.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed requests, random sets, drain.
  initial begin
    int kind;
    int len;
    bit restart_first;
    rst = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.value   = '0;
    req_ch.restart = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // No restart after reset: the first words form a set already in progress.
    send_request('0, 1'b0, 1'b0);
    send_request('1, 1'b0, 1'b0);
    send_request('0, 1'b0, 1'b0);
    send_request(64'h8000_0000_0000_0001, 1'b0, 1'b0);
    send_request('1, 1'b0, 1'b0);
    // A restart clears the uniques, so an earlier value is kept again.
    send_request('0, 1'b1, 1'b0);
    send_request('0, 1'b0, 1'b0);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
    send_request(64'h5555_5555_5555_5555, 1'b0, 1'b0);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
    // Back-to-back restarts with the same value.
    send_request(64'h5555_5555_5555_5555, 1'b1, 1'b0);
    send_request(64'h5555_5555_5555_5555, 1'b1, 1'b0);
    send_request(64'h0000_0000_0000_0001, 1'b0, 1'b0);
    send_request(64'h0000_0000_0000_0002, 1'b0, 1'b0);

    // The result side holds off while a full set with overflow goes in.
    hold_due = 1'b1;
    send_set(68, 68, 1'b1, 1'b1);

    while (sb.n_requests < N_REQUESTS) begin
      kind = $urandom_range(0, 19);
      restart_first = ($urandom_range(0, 9) != 0);
      if (kind < 13) begin
        len = $urandom_range(1, 24);
        send_set(len, $urandom_range(1, len), 1'b0, restart_first);
      end else if (kind < 16) begin
        len = $urandom_range(25, 63);
        send_set(len, $urandom_range(1, len), 1'b0, restart_first);
      end else if (kind < 18) begin
        send_set($urandom_range(64, 80), 80, 1'b1, restart_first);
      end else begin
        send_set($urandom_range(64, 76), $urandom_range(8, 40), 1'b0, restart_first);
      end
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("Sent %0d requests in %0d restarted sets: %0d kept, %0d repeats, %0d overflowed.",
             sb.n_requests, sb.n_sets, sb.n_kept, sb.n_repeats, sb.n_overflow);
    $display("Checked %0d results with %0d mismatches, including a %0d-cycle output hold-off.",
             sb.n_results, sb.errors, HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### stream_duplicate_remover.f
hw/rtl/sdr_pkg.sv
hw/rtl/sdr_if.sv
hw/rtl/sdr_cell.sv
hw/rtl/stream_duplicate_remover.sv
sim/tb.sv
